/* hw/rtl/exprt_pkg.sv */
// Package for the fixed-point e^x core: Q.32 constants, result width,
// sequencer and multiplier state codes, and the multiply request/response structs.
// No dependencies.
package exprt_pkg;

  // Result width (unsigned, FRAC_BITS fraction bits)
  localparam int VALUE_W = 40;
  // Internal Q.32 word and width of the narrow multiplier operand
  localparam int Q_W     = 64;
  localparam int B_W     = 34;
  // Multiplier lane widths: low half of the wide operand, and the full product
  localparam int HALF_W  = 32;
  localparam int PROD_W  = HALF_W + B_W;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // Q.32 constants, rounded to nearest
  localparam logic [Q_W-1:0] Q_ONE     = 64'd4294967296;
  localparam logic [B_W-1:0] Q_E       = 34'd11674931555;
  localparam logic [B_W-1:0] Q_INV_E   = 34'd1580030169;
  localparam logic [B_W-1:0] Q_HALF    = 34'd2147483648;
  localparam logic [B_W-1:0] Q_THIRD   = 34'd1431655765;
  localparam logic [B_W-1:0] Q_QUARTER = 34'd1073741824;
  localparam logic [B_W-1:0] Q_FIFTH   = 34'd858993459;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_OUT
  } seq_state_t;

  // Multiply steps: integer power, then Horner terms, then the final product
  typedef enum logic [3:0] {
    OP_POW,
    OP_P5,
    OP_U4,
    OP_T4,
    OP_U3,
    OP_T3,
    OP_U2,
    OP_T2,
    OP_P,
    OP_FIN
  } op_t;

  // Shared multiplier phases
  typedef enum logic [1:0] {
    MP_IDLE,
    MP_LOW,
    MP_HIGH
  } mul_phase_t;

  // One Q.32 multiply: floor(a * b / 2^32)
  typedef struct packed {
    logic           start;
    logic [Q_W-1:0] a;
    logic [B_W-1:0] b;
  } qmul_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] res;
  } qmul_rsp_t;

endpackage

/* hw/rtl/exp_range_reduced_taylor_core.sv */
// Each Q.32 multiply uses the shared 32x34 multiplier; an item takes at most n + 9 multiplies,
// n = |floor(x)| (0..16 at default width), fewer when the integer power saturates.
// One item at a time: s_axis_tready is high only while the sequencer is idle.
// A finished result waits in the output register while the next beat is taken.
// Reset: rst, synchronous, active high, clears sequencer, multiplier and tvalid.
// Top level of the e^x core; uses exprt_pkg, exprt_seq and exprt_qmul.
module exp_range_reduced_taylor_core #(
  parameter int INT_BITS  = 5,
  parameter int FRAC_BITS = 16,
  localparam int ARG_W      = INT_BITS + FRAC_BITS,
  localparam int IN_TDATA_W = ((ARG_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [IN_TDATA_W-1:0]         s_axis_tdata,  // [ARG_W-1:0] arg
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [exprt_pkg::VALUE_W-1:0] m_axis_tdata   // [39:0] value
);

  exprt_pkg::qmul_req_t              mul_req;
  exprt_pkg::qmul_rsp_t              mul_rsp;
  logic                              res_valid;
  logic                              res_ready;
  logic [exprt_pkg::VALUE_W-1:0]     res_value;

  exprt_seq #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_arg    (s_axis_tdata[ARG_W-1:0]),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .out_value (res_value),
    .mul_req   (mul_req),
    .mul_rsp   (mul_rsp)
  );

  exprt_qmul u_qmul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // Output register: loads when empty or being drained
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) m_axis_tdata <= res_value;
  end

`ifndef SYNTH
  // A taken input beat makes the core busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("core ready again right after taking a beat");

  // Every multiply request is answered by a done pulse after the LOW and HIGH phases
  a_mul_latency: assert property (@(posedge clk) disable iff (rst)
    mul_req.start |-> ##3 mul_rsp.done)
    else $error("multiplier response missing");

  // A result handed over always shows up on the output
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> m_axis_tvalid)
    else $error("result lost at output register");
`endif

endmodule

/* hw/rtl/exprt_qmul.sv */
// Shared Q.32 multiplier: one 32x34 multiplier used twice per request.
// Depends on exprt_pkg.
module exprt_qmul (
  input  logic                 clk,
  input  logic                 rst,
  input  exprt_pkg::qmul_req_t req,
  output exprt_pkg::qmul_rsp_t rsp
);

  exprt_pkg::mul_phase_t             phase;
  exprt_pkg::mul_phase_t             phase_next;
  logic [exprt_pkg::HALF_W-1:0]      a_hi;
  logic [exprt_pkg::B_W-1:0]         b_q;
  logic [exprt_pkg::PROD_W-1:0]      prod;
  logic [exprt_pkg::B_W-1:0]         lo;
  logic [exprt_pkg::Q_W-1:0]         res;
  logic                              done;
  logic [exprt_pkg::HALF_W-1:0]      mul_a;
  logic [exprt_pkg::B_W-1:0]         mul_b;
  logic [exprt_pkg::PROD_W-1:0]      mul_p;

  // Low half of a on the first beat, high half on the second
  always_comb begin
    if (phase == exprt_pkg::MP_IDLE) begin
      mul_a = req.a[exprt_pkg::HALF_W-1:0];
      mul_b = req.b;
    end else begin
      mul_a = a_hi;
      mul_b = b_q;
    end
    mul_p = {{exprt_pkg::B_W{1'b0}}, mul_a} * {{exprt_pkg::HALF_W{1'b0}}, mul_b};
  end

  // Phase sequencing
  always_comb begin
    phase_next = phase;
    case (phase)
      exprt_pkg::MP_IDLE: begin
        if (req.start) phase_next = exprt_pkg::MP_LOW;
      end
      exprt_pkg::MP_LOW:  phase_next = exprt_pkg::MP_HIGH;
      exprt_pkg::MP_HIGH: phase_next = exprt_pkg::MP_IDLE;
      default:            phase_next = exprt_pkg::MP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= exprt_pkg::MP_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == exprt_pkg::MP_HIGH);
    end
  end

  // Partial products and recombination: a_hi*b + (a_lo*b >> 32)
  always_ff @(posedge clk) begin
    case (phase)
      exprt_pkg::MP_IDLE: begin
        if (req.start) begin
          prod <= mul_p;
          a_hi <= req.a[exprt_pkg::Q_W-1:exprt_pkg::HALF_W];
          b_q  <= req.b;
        end
      end
      exprt_pkg::MP_LOW: begin
        prod <= mul_p;
        lo   <= prod[exprt_pkg::PROD_W-1:exprt_pkg::HALF_W];
      end
      exprt_pkg::MP_HIGH: begin
        res <= prod[exprt_pkg::Q_W-1:0]
               + {{(exprt_pkg::Q_W-exprt_pkg::B_W){1'b0}}, lo};
      end
      default: ;
    endcase
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule

/* hw/rtl/exprt_seq.sv */
// Sequencer for e^x: range reduction, integer power loop, Horner polynomial,
// final product and output scaling. Drives exprt_qmul; depends on exprt_pkg.
module exprt_seq #(
  parameter int INT_BITS  = 5,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [INT_BITS+FRAC_BITS-1:0] in_arg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [exprt_pkg::VALUE_W-1:0] out_value,
  output exprt_pkg::qmul_req_t          mul_req,
  input  exprt_pkg::qmul_rsp_t          mul_rsp
);

  localparam int ARG_W = INT_BITS + FRAC_BITS;
  localparam int SHIFT = exprt_pkg::HALF_W - FRAC_BITS;

  exprt_pkg::seq_state_t             state;
  exprt_pkg::seq_state_t             state_next;
  exprt_pkg::op_t                    op;
  exprt_pkg::op_t                    op_next;
  logic [INT_BITS-1:0]               count;
  logic                              use_e;
  logic [exprt_pkg::Q_W-1:0]         run;
  logic [exprt_pkg::B_W-1:0]         t;
  logic [exprt_pkg::HALF_W-1:0]      u;
  logic [exprt_pkg::HALF_W-1:0]      f;
  logic [exprt_pkg::VALUE_W-1:0]     value;

  logic                              neg;
  logic [INT_BITS-1:0]               ipart;
  logic [INT_BITS-1:0]               steps;
  logic [exprt_pkg::HALF_W-1:0]      f_in;
  logic                              run_over;
  logic [exprt_pkg::Q_W-1:0]         v_full;
  logic                              fin_over;
  logic [exprt_pkg::Q_W-1:0]         one_plus;
  logic                              mul_start;

  // Split x into floor(x) and the fraction, fraction scaled to Q.32
  always_comb begin
    neg   = in_arg[ARG_W-1];
    ipart = in_arg[ARG_W-1:FRAC_BITS];
    steps = neg ? INT_BITS'(~ipart + 1'b1) : ipart;
    f_in  = exprt_pkg::HALF_W'(in_arg[FRAC_BITS-1:0]) << SHIFT;
  end

  // Checks and sums on the multiplier result
  always_comb begin
    run_over = |mul_rsp.res[exprt_pkg::Q_W-1:exprt_pkg::Q_W-2];
    v_full   = mul_rsp.res >> SHIFT;
    fin_over = |v_full[exprt_pkg::Q_W-1:exprt_pkg::VALUE_W];
    one_plus = exprt_pkg::Q_ONE + mul_rsp.res;
  end

  // Operands for each step
  always_comb begin
    mul_req.start = mul_start;
    mul_req.a = {{exprt_pkg::HALF_W{1'b0}}, f};
    mul_req.b = t;
    case (op)
      exprt_pkg::OP_POW: begin
        mul_req.a = run;
        mul_req.b = use_e ? exprt_pkg::Q_E : exprt_pkg::Q_INV_E;
      end
      exprt_pkg::OP_P5: mul_req.b = exprt_pkg::Q_FIFTH;
      exprt_pkg::OP_U4: mul_req.b = exprt_pkg::Q_QUARTER;
      exprt_pkg::OP_U3: mul_req.b = exprt_pkg::Q_THIRD;
      exprt_pkg::OP_U2: mul_req.b = exprt_pkg::Q_HALF;
      exprt_pkg::OP_T4, exprt_pkg::OP_T3, exprt_pkg::OP_T2: begin
        mul_req.a = {{exprt_pkg::HALF_W{1'b0}}, u};
      end
      exprt_pkg::OP_FIN: mul_req.a = run;
      default: ;
    endcase
  end

  // Next state and handshake outputs
  always_comb begin
    state_next    = state;
    op_next       = op;
    mul_start     = 1'b0;
    in_ready      = (state == exprt_pkg::S_IDLE);
    out_valid     = (state == exprt_pkg::S_OUT);
    case (state)
      exprt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = exprt_pkg::S_ISSUE;
          op_next    = (steps == '0) ? exprt_pkg::OP_P5 : exprt_pkg::OP_POW;
        end
      end
      exprt_pkg::S_ISSUE: begin
        mul_start     = 1'b1;
        state_next    = exprt_pkg::S_WAIT;
      end
      exprt_pkg::S_WAIT: begin
        if (mul_rsp.done) begin
          state_next = exprt_pkg::S_ISSUE;
          case (op)
            exprt_pkg::OP_POW: begin
              if (run_over) begin
                state_next = exprt_pkg::S_OUT;
              end else if (count == INT_BITS'(1)) begin
                op_next = exprt_pkg::OP_P5;
              end
            end
            exprt_pkg::OP_P5:  op_next = exprt_pkg::OP_U4;
            exprt_pkg::OP_U4:  op_next = exprt_pkg::OP_T4;
            exprt_pkg::OP_T4:  op_next = exprt_pkg::OP_U3;
            exprt_pkg::OP_U3:  op_next = exprt_pkg::OP_T3;
            exprt_pkg::OP_T3:  op_next = exprt_pkg::OP_U2;
            exprt_pkg::OP_U2:  op_next = exprt_pkg::OP_T2;
            exprt_pkg::OP_T2:  op_next = exprt_pkg::OP_P;
            exprt_pkg::OP_P:   op_next = exprt_pkg::OP_FIN;
            exprt_pkg::OP_FIN: state_next = exprt_pkg::S_OUT;
            default:           state_next = exprt_pkg::S_IDLE;
          endcase
        end
      end
      exprt_pkg::S_OUT: begin
        if (out_ready) state_next = exprt_pkg::S_IDLE;
      end
      default: state_next = exprt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= exprt_pkg::S_IDLE;
      op    <= exprt_pkg::OP_POW;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (state == exprt_pkg::S_IDLE && in_valid) begin
      f     <= f_in;
      count <= steps;
      use_e <= !neg;
      run   <= exprt_pkg::Q_ONE;
    end
    if (state == exprt_pkg::S_WAIT && mul_rsp.done) begin
      case (op)
        exprt_pkg::OP_POW: begin
          run   <= mul_rsp.res;
          count <= count - 1'b1;
          // running value out of range: result saturates
          if (run_over) value <= exprt_pkg::VALUE_MAX;
        end
        exprt_pkg::OP_U4, exprt_pkg::OP_U3, exprt_pkg::OP_U2: begin
          u <= mul_rsp.res[exprt_pkg::HALF_W-1:0];
        end
        exprt_pkg::OP_FIN: begin
          value <= fin_over ? exprt_pkg::VALUE_MAX : v_full[exprt_pkg::VALUE_W-1:0];
        end
        default: t <= one_plus[exprt_pkg::B_W-1:0];
      endcase
    end
  end

  assign out_value = value;

endmodule

/* sim/exp_taylor_checker.sv */
// Scoreboard for the e^x core: predicts each result from the argument beats and
// compares it with the output beats in order.
// Stand-alone; needs only the stream signals of exp_range_reduced_taylor_core.
module exp_taylor_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // [20:0] arg
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [39:0] value
  output int          mismatches,
  output int          outstanding,
  output int          args_seen,
  output int          results_seen,
  output int          zero_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // Q.32 constants, rounded to nearest
  localparam logic [63:0] ONE_Q32     = 64'd4294967296;
  localparam logic [63:0] E_Q32       = 64'd11674931555;
  localparam logic [63:0] INV_E_Q32   = 64'd1580030169;
  localparam logic [63:0] HALF_Q32    = 64'd2147483648;
  localparam logic [63:0] THIRD_Q32   = 64'd1431655765;
  localparam logic [63:0] QUARTER_Q32 = 64'd1073741824;
  localparam logic [63:0] FIFTH_Q32   = 64'd858993459;
  localparam logic [63:0] POWER_LIMIT = 64'h4000_0000_0000_0000;
  localparam logic [39:0] VALUE_SAT   = {40{1'b1}};

  typedef struct {
    logic [20:0] arg;
    logic [39:0] value;
  } exp_result_t;

  exp_result_t expected_exp_q[$];

  // floor(a * b / 2^32) on a full-width product
  function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[95:32];
  endfunction

  // e^x for a Q5.16 argument, result in Q24.16
  function automatic logic [39:0] exp_of_arg(input logic [20:0] x);
    logic        neg;
    logic        pos;
    logic        sat;
    logic [5:0]  steps;
    logic [63:0] f;
    logic [63:0] factor;
    logic [63:0] power;
    logic [63:0] t;
    logic [63:0] poly;
    logic [63:0] scaled;
    int          i;
    neg = x[20];
    pos = !neg && (x != 21'd0);
    f   = {32'd0, x[15:0], 16'd0};
    // integer part: k steps of e, or |k| steps of 1/e (zero steps for x = 0)
    if (pos) begin
      steps  = {1'b0, x[20:16]};
      factor = E_Q32;
    end else begin
      steps  = neg ? (6'd32 - {1'b0, x[20:16]}) : 6'd0;
      factor = INV_E_Q32;
    end
    power = ONE_Q32;
    sat   = 1'b0;
    for (i = 0; i < 32; i++) begin
      if (i < steps && !sat) begin
        power = mul_q32(power, factor);
        if (power >= POWER_LIMIT) sat = 1'b1;
      end
    end
    // nested Horner form of the fifth-order series for e^f
    t    = ONE_Q32 + mul_q32(f, FIFTH_Q32);
    t    = ONE_Q32 + mul_q32(mul_q32(f, QUARTER_Q32), t);
    t    = ONE_Q32 + mul_q32(mul_q32(f, THIRD_Q32), t);
    t    = ONE_Q32 + mul_q32(mul_q32(f, HALF_Q32), t);
    poly = ONE_Q32 + mul_q32(f, t);
    if (sat) return VALUE_SAT;
    scaled = mul_q32(power, poly) >> 16;
    if (scaled > {24'd0, VALUE_SAT}) return VALUE_SAT;
    return scaled[39:0];
  endfunction

  // queue a prediction per argument beat, check each result beat against the oldest
  always @(posedge clk) begin
    exp_result_t exp_item;
    exp_result_t got;
    if (rst) begin
      mismatches   <= 0;
      outstanding  <= 0;
      args_seen    <= 0;
      results_seen <= 0;
      zero_results <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        exp_item.arg   = s_tdata[20:0];
        exp_item.value = exp_of_arg(s_tdata[20:0]);
        expected_exp_q = {expected_exp_q, exp_item};
        args_seen <= args_seen + 1;
      end
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (m_tdata == 40'd0) zero_results <= zero_results + 1;
        if (expected_exp_q.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, got value %h", $time, m_tdata);
          mismatches <= mismatches + 1;
        end else begin
          got = expected_exp_q.pop_front();
          if (m_tdata !== got.value) begin
            $display("%0t: value mismatch for arg %h: expected %h, got %h",
                     $time, got.arg, got.value, m_tdata);
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= expected_exp_q.size();
    end
  end

endmodule

/* sim/exp_range_reduced_taylor_core_tb.sv */
// Testbench top for the e^x core: clock, reset, argument stimulus, output
// back-pressure, watchdog and verdict. Uses exp_taylor_checker for prediction.
module exp_range_reduced_taylor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W           = 24;
  localparam int RANDOM_PER_PH  = 385;
  localparam int NUM_PHASES     = 5;
  localparam int HOLD_CYCLES    = 600;
  localparam int MAX_GAP        = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 150;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;   // [20:0] arg
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [39:0]     m_axis_tdata;        // [39:0] value

  int mismatches;
  int outstanding;
  int args_seen;
  int results_seen;
  int zero_results;

  // per-phase idle rates, percent of cycles
  int send_idle  = 0;
  int recv_stall = 0;
  // hold-off request from the stimulus; the back-pressure process marks it served
  logic hold_off  = 1'b0;
  logic hold_done = 1'b0;

  int send_idle_pct[NUM_PHASES]  = '{0, 73, 0, 38, 0};
  int recv_stall_pct[NUM_PHASES] = '{0, 0, 73, 38, 0};

  // zero, extremes, +-1 LSB, unit steps, underflow, and bits above the arg field
  logic [IN_W-1:0] directed_args[21] = '{
    24'h000000, 24'h000001, 24'h0FFFFF, 24'h100000, 24'h1FFFFF, 24'h010000,
    24'h1F0000, 24'h008000, 24'h1F8000, 24'h00FFFF, 24'h0F0000, 24'h0F8000,
    24'h100001, 24'h150000, 24'h140000, 24'h1C0000, 24'h0A5A5A, 24'h1E0001,
    24'hE00000, 24'hFFFFFF, 24'h20FFFF
  };

  always #5 clk = ~clk;

  exp_range_reduced_taylor_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  exp_taylor_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_axis_tvalid),
    .s_tready     (s_axis_tready),
    .s_tdata      (s_axis_tdata),
    .m_tvalid     (m_axis_tvalid),
    .m_tready     (m_axis_tready),
    .m_tdata      (m_axis_tdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .args_seen    (args_seen),
    .results_seen (results_seen),
    .zero_results (zero_results)
  );

  // Random argument: mostly uniform, some near zero, some at integer boundaries
  function automatic logic [IN_W-1:0] random_arg();
    int          pick;
    logic [20:0] near;
    logic [15:0] frac;
    pick = $urandom_range(9);
    if (pick < 6) return IN_W'($urandom);
    if (pick < 8) begin
      near = 21'($urandom_range(262143)) - 21'd131072;
      return {3'($urandom), near};
    end
    case ($urandom_range(2))
      0: frac = 16'h0000;
      1: frac = 16'h0001;
      default: frac = 16'hFFFF;
    endcase
    return {3'($urandom), 5'($urandom), frac};
  endfunction

  // Offer one argument beat after a random gap; returns once it is taken
  task automatic send_arg(input logic [IN_W-1:0] word);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Output back-pressure, with one long hold-off on request
  always begin
    @(negedge clk);
    if (hold_off && !hold_done) begin
      m_axis_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_done = 1'b1;
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  // Watchdog: ends the run after too long without any beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // Stimulus and verdict
  initial begin : stimulus
    int ph;
    int n;
    int failures;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle  = send_idle_pct[ph];
      recv_stall = recv_stall_pct[ph];
      // last phase: long receiver hold-off while arguments keep coming
      if (ph == NUM_PHASES - 1) hold_off = 1'b1;
      if (ph == 0) begin
        foreach (directed_args[i]) send_arg(directed_args[i]);
      end
      for (n = 0; n < RANDOM_PER_PH; n++) send_arg(random_arg());
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    // drain, then allow for one more full-latency window
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    failures = mismatches + outstanding;
    $display("Run covered %0d arguments (%0d directed) and %0d results, %0d underflowed to zero,",
             args_seen, $size(directed_args), results_seen, zero_results);
    $display("over %0d idle/stall phases with one %0d-cycle output hold-off.",
             NUM_PHASES, HOLD_CYCLES);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
